// ----- rtl/core/bracket_command_frame_parser_assert.svh -----
// assertion macros for the bracket command frame parser
`ifndef BRACKET_COMMAND_FRAME_PARSER_ASSERT_SVH
`define BRACKET_COMMAND_FRAME_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BCFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    `BCFP_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define BCFP_ASSERT(lbl, prop, msg)
`define BCFP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/bcfp_pkg.sv -----
// constants and helpers for the bracket command frame parser
package bcfp_pkg;

    localparam int STORE_DEPTH = 18;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef logic [7:0]        char_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam char_t CH_LBRACK = 8'h5B;
    localparam char_t CH_RBRACK = 8'h5D;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5A;
    localparam char_t CH_UP_F   = 8'h46;
    localparam char_t CH_LO_A   = 8'h61;
    localparam char_t CH_LO_F   = 8'h66;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input char_t c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_hex(input char_t c);
        return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
               ((c >= CH_LO_A) && (c <= CH_LO_F));
    endfunction

endpackage

// ----- rtl/core/bcfp_ram.sv -----
// generic single-write, single-read ram with registered read data
module bcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bracket_command_frame_parser.sv -----
// bracket command frame parser: frame recognizer, data store and frame replay
// after the closing ']', replay registers '[' first once the output register is free
// throughput: one input character per cycle while parsing; a frame of 2N+4 characters
// replays one per cycle, data from the ram, while m_tready is high; input held off
// reset: state, counters and output valid clear at once; the data ram is not cleared
`include "bracket_command_frame_parser_assert.svh"
module bracket_command_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bcfp_pkg::char_t   s_tdata,   // [7:0] in_char
    output logic              m_tvalid,
    input  logic              m_tready,
    output bcfp_pkg::char_t   m_tdata,   // [7:0] frame_char
    output logic              m_tlast    // frame_last
);
    import bcfp_pkg::*;

    localparam logic [3:0] ST_WAIT    = 4'd0;
    localparam logic [3:0] ST_CMD     = 4'd1;
    localparam logic [3:0] ST_LEN     = 4'd2;
    localparam logic [3:0] ST_DATA    = 4'd3;
    localparam logic [3:0] ST_END     = 4'd4;
    localparam logic [3:0] ST_E_OPEN  = 4'd5;
    localparam logic [3:0] ST_E_CMD   = 4'd6;
    localparam logic [3:0] ST_E_LEN   = 4'd7;
    localparam logic [3:0] ST_E_DATA  = 4'd8;
    localparam logic [3:0] ST_E_CLOSE = 4'd9;

    logic [3:0] state_reg, state_next;
    char_t      cmd_reg, cmd_next;
    logic [3:0] len_reg, len_next;
    count_t     count_reg, count_next;
    count_t     idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    char_t      m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;

    logic   in_xfer;
    logic   out_free;
    logic   emitting;
    logic   ram_we;
    logic   ram_re;
    char_t  ram_rdata;

    assign emitting = (state_reg >= ST_E_OPEN);
    assign s_tready = !emitting;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign ram_we = in_xfer && (s_tdata != CH_LBRACK) && (state_reg == ST_DATA) &&
                    is_hex(s_tdata) && (count_reg < count_t'(STORE_DEPTH));
    // read address runs one step ahead so back-to-back data characters see fresh data;
    // writes end before the end state and the replay header, so no forwarding
    assign ram_re = (idx_next < count_t'(STORE_DEPTH));

    bcfp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;

        if (in_xfer)
        begin
            if (s_tdata == CH_LBRACK)
            begin
                state_next = ST_CMD;
                count_next = '0;
            end
            else
            begin
                case (state_reg)
                    ST_WAIT:
                    begin
                        state_next = ST_WAIT;
                    end
                    ST_CMD:
                    begin
                        if (is_upper(s_tdata))
                        begin
                            cmd_next   = s_tdata;
                            state_next = ST_LEN;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    ST_LEN:
                    begin
                        if (is_digit(s_tdata))
                        begin
                            len_next   = s_tdata[3:0];
                            state_next = (s_tdata[3:0] == 4'd0) ? ST_END : ST_DATA;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    ST_DATA:
                    begin
                        if (ram_we)
                        begin
                            count_next = count_reg + count_t'(1);
                            if ((count_reg + count_t'(1)) == {len_reg, 1'b0})
                            begin
                                state_next = ST_END;
                            end
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                            count_next = '0;
                        end
                    end
                    ST_END:
                    begin
                        if (s_tdata == CH_RBRACK)
                        begin
                            state_next = ST_E_OPEN;
                            idx_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_WAIT;
                    end
                endcase
            end
        end
        else if (emitting && out_free)
        begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            case (state_reg)
                ST_E_OPEN:
                begin
                    m_data_next = CH_LBRACK;
                    state_next  = ST_E_CMD;
                end
                ST_E_CMD:
                begin
                    m_data_next = cmd_reg;
                    state_next  = ST_E_LEN;
                end
                ST_E_LEN:
                begin
                    m_data_next = {4'h3, len_reg};
                    state_next  = (count_reg == '0) ? ST_E_CLOSE : ST_E_DATA;
                end
                ST_E_DATA:
                begin
                    m_data_next = ram_rdata;
                    idx_next    = idx_reg + count_t'(1);
                    if ((idx_reg + count_t'(1)) == count_reg)
                    begin
                        state_next = ST_E_CLOSE;
                    end
                end
                ST_E_CLOSE:
                begin
                    m_data_next = CH_RBRACK;
                    m_last_next = 1'b1;
                    state_next  = ST_WAIT;
                    count_next  = '0;
                    idx_next    = '0;
                end
                default:
                begin
                    m_valid_next = m_valid_reg && !m_tready;
                    state_next   = ST_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_WAIT;
            cmd_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `BCFP_ASSERT_IMPL(a_idx_in_range, state_reg == ST_E_DATA, idx_reg < count_reg,
                      "replay index past data count")
    `BCFP_ASSERT_IMPL(a_last_is_close, m_tvalid && m_tlast, m_tdata == CH_RBRACK,
                      "frame end flag on a character other than close bracket")
    `BCFP_ASSERT_IMPL(a_no_write_in_replay, ram_we, !emitting,
                      "data store written during frame replay")
    `BCFP_ASSERT_IMPL(a_count_bound, state_reg == ST_DATA,
                      count_reg < (count_t'(len_reg) << 1),
                      "data count reached length outside data phase exit")

endmodule

// ----- sim/tb_top.sv -----
// testbench for the bracket command frame parser: directed and random streams
module tb_top;
    import bcfp_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_OPEN,
        AWAIT_CMD,
        AWAIT_LEN,
        AWAIT_DATA,
        AWAIT_CLOSE
    } parse_state_t;

    typedef struct packed {
        char_t ch;
        logic  last;
    } frame_beat_t;

    logic  clk;
    logic  rst_n;
    logic  s_tvalid;
    logic  s_tready;
    char_t s_tdata;   // [7:0] in_char
    logic  m_tvalid;
    logic  m_tready;
    char_t m_tdata;   // [7:0] frame_char
    logic  m_tlast;   // frame_last

    // predictor state
    parse_state_t parse_state = AWAIT_OPEN;
    char_t        cmd_letter  = '0;
    logic [3:0]   len_value   = '0;
    logic [4:0]   data_taken  = '0;
    char_t        data_mem [STORE_DEPTH];

    frame_beat_t  replay_expect_q[$];

    int send_gap_pct   = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int chars_sent     = 0;
    int frames_expected = 0;
    int beats_checked  = 0;
    bit max_frame_due  = 1'b1;

    string hex_digits = "0123456789ABCDEFabcdef";
    string near_miss  = "/:@G`g[]x";

    bracket_command_frame_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // advance the frame predictor by one accepted character
    function automatic void parse_char(input char_t c);
        logic hex_ok;
        int   i;
        hex_ok = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
                 (c >= CH_LO_A && c <= CH_LO_F);
        if (c == CH_LBRACK)
        begin
            parse_state = AWAIT_CMD;
            data_taken  = '0;
            return;
        end
        case (parse_state)
            AWAIT_OPEN: ;
            AWAIT_CMD:
                if (c >= CH_UP_A && c <= CH_UP_Z)
                begin
                    cmd_letter  = c;
                    parse_state = AWAIT_LEN;
                end
                else
                begin
                    parse_state = AWAIT_OPEN;
                end
            AWAIT_LEN:
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    len_value   = 4'(c - CH_ZERO);
                    parse_state = (len_value == 4'd0) ? AWAIT_CLOSE : AWAIT_DATA;
                end
                else
                begin
                    parse_state = AWAIT_OPEN;
                end
            AWAIT_DATA:
                if (hex_ok && int'(data_taken) < STORE_DEPTH)
                begin
                    data_mem[data_taken] = c;
                    data_taken = data_taken + 5'd1;
                    if (int'(data_taken) == 2 * int'(len_value))
                        parse_state = AWAIT_CLOSE;
                end
                else
                begin
                    parse_state = AWAIT_OPEN;
                    data_taken  = '0;
                end
            AWAIT_CLOSE:
            begin
                parse_state = AWAIT_OPEN;
                if (c == CH_RBRACK)
                begin
                    replay_expect_q.push_back(frame_beat_t'{ch: CH_LBRACK, last: 1'b0});
                    replay_expect_q.push_back(frame_beat_t'{ch: cmd_letter, last: 1'b0});
                    replay_expect_q.push_back(
                        frame_beat_t'{ch: char_t'(CH_ZERO + len_value), last: 1'b0});
                    for (i = 0; i < int'(data_taken); i++)
                        replay_expect_q.push_back(frame_beat_t'{ch: data_mem[i], last: 1'b0});
                    replay_expect_q.push_back(frame_beat_t'{ch: CH_RBRACK, last: 1'b1});
                    data_taken = '0;
                    frames_expected++;
                end
            end
            default: parse_state = AWAIT_OPEN;
        endcase
    endfunction

    // one character transfer on the input side, with random gaps ahead of it
    task automatic send_char(input char_t c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_char(char_t'(text[i]));
    endtask

    // each frame transfer checked against the oldest expected character
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replay_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected frame char %h last %b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                want = replay_expect_q.pop_front();
                beats_checked++;
                if (m_tdata !== want.ch)
                    report_mismatch($sformatf("frame_char %h, expected %h", m_tdata, want.ch));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("frame_last %b, expected %b on char %h",
                                              m_tlast, want.last, want.ch));
            end
        end
    end

    // all-zero and all-one bytes while waiting are ignored
    task automatic test_idle_chars;
        send_char(8'h00);
        send_char(8'hFF);
    endtask

    task automatic test_zero_length;
        send_text("[A0]");
    endtask

    // a second open bracket drops the partial frame
    task automatic test_restart;
        send_text("[B1[Z1fF]");
    endtask

    task automatic test_broken_format;
        send_text("[a");
        send_text("[C:");
        send_text("[D1g");
        send_text("[E0x");
    endtask

    task automatic test_random_frames(input int gap_pct, input int stall_pct, input int budget);
        char_t seq_q[$];
        int    sent;
        int    n;
        int    pick;
        int    cut;
        bit    broken;
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            seq_q.delete();
            if (pick < 10)
            begin
                // line noise between frames
                repeat ($urandom_range(1, 4))
                    seq_q.push_back(char_t'($urandom_range(255)));
            end
            else
            begin
                broken = (pick >= 75) && !max_frame_due;
                n = max_frame_due ? 9 : $urandom_range(9);
                max_frame_due = 1'b0;
                seq_q.push_back(CH_LBRACK);
                seq_q.push_back(char_t'(CH_UP_A + $urandom_range(25)));
                seq_q.push_back(char_t'(CH_ZERO + n));
                repeat (2 * n)
                    seq_q.push_back(char_t'(hex_digits[$urandom_range(21)]));
                seq_q.push_back(CH_RBRACK);
                if (broken)
                begin
                    cut = $urandom_range(1, seq_q.size() - 1);
                    if ($urandom_range(1))
                        seq_q[cut] = char_t'(near_miss[$urandom_range(near_miss.len() - 1)]);
                    else
                        seq_q[cut] = char_t'($urandom_range(255));
                    if ($urandom_range(1))
                        seq_q = seq_q[0:cut];
                end
                sent += seq_q.size();
            end
            foreach (seq_q[i])
                send_char(seq_q[i]);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_chars();
        test_zero_length();
        test_restart();
        test_broken_format();
        test_random_frames(0, 0, 108);
        test_random_frames(82, 0, 108);
        test_random_frames(0, 82, 108);
        test_random_frames(21, 21, 108);

        s_tvalid <= 1'b0;
        while (replay_expect_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d characters; %0d frames replayed, %0d frame characters checked",
                 chars_sent, frames_expected, beats_checked);
        $display("stream phases: no idling, sender gaps, receiver stalls, and both together");
        if (error_count == 0)
            $display("bracket_command_frame_parser regression: pass");
        else
            $display("bracket_command_frame_parser regression: fail");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d frame characters outstanding", replay_expect_q.size());
        $display("bracket_command_frame_parser regression: fail");
        $finish;
    end

endmodule
